FILE: hw/rtl/md5_pkg.sv
// Shared types, constants and round functions for the MD5 digest engine.
package md5_pkg;

    typedef logic [3:0][31:0] md5_words_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] round;
    } md5_round_ctrl_t;

    localparam logic [31:0] MD5_INIT [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [7:0] MD5_PAD_BYTE = 8'h80;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Index of the message word used in a given round.
    function automatic logic [3:0] md5_msg_index(input logic [5:0] round);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = round[3:0];
        unique case (round[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'(4'(r4 * 4'd5) + 4'd1);
            2'd2:    idx = 4'(4'(r4 * 4'd3) + 4'd5);
            default: idx = 4'(r4 * 4'd7);
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] round);
        return MD5_S[{round[5:4], round[1:0]}];
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    // Puts a byte into its lane; the first lane clears the rest of the word.
    function automatic logic [31:0] md5_put_byte(input logic [31:0] word,
                                                 input logic [1:0]  lane,
                                                 input logic [7:0]  data);
        logic [31:0] res;
        res = (lane == 2'd0) ? 32'd0 : word;
        res[8*lane +: 8] = data;
        return res;
    endfunction

endpackage

FILE: hw/rtl/md5_round.sv
// Shared MD5 round unit holding the working words a, b, c and d.
module md5_round (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  md5_pkg::md5_round_ctrl_t ctrl,
    input  md5_pkg::md5_words_t      cv_in,
    input  logic [31:0]              msg_word,
    output md5_pkg::md5_words_t      work_out
);
    import md5_pkg::*;

    md5_words_t  work_reg;
    md5_words_t  work_next;
    logic [31:0] f_val;
    logic [31:0] sum_val;

    always_comb begin
        unique case (ctrl.round[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[3] & work_reg[1]) | (~work_reg[3] & work_reg[2]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        sum_val = work_reg[0] + f_val + MD5_K[ctrl.round] + msg_word;
    end

    always_comb begin
        work_next = work_reg;
        priority if (ctrl.load) begin
            work_next = cv_in;
        end else if (ctrl.step) begin
            work_next[0] = work_reg[3];
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[1] + md5_rotl(sum_val, md5_rot(ctrl.round));
        end else begin
            work_next = work_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= '0;
        end else begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

FILE: hw/rtl/md5_digest_engine.sv
// Top level of the MD5 digest engine: byte packing, padding, sequencing and output.
// A data byte that does not complete a 64-byte block is only stored; one that completes it
// starts 64 rounds on the shared round unit and one chaining add. A closing byte that fills a
// block has that block compressed first; then a pad step and, per padded block, 64 rounds and
// one chaining add (an extra length block if the pad falls at byte 56 or later), then h0 to h3.
// Synchronous active-low reset restores the initial chaining value and a zero byte count.
module md5_digest_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_EXTRA = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_EXTRA = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0]      state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic            eom_reg, eom_next;
    logic [5:0]      round_reg, round_next;
    logic [1:0]      oidx_reg, oidx_next;
    logic [60:0]     count_reg, count_next;
    md5_words_t      cv_reg, cv_next;
    logic [31:0]     buf_reg [16];
    logic [31:0]     buf_next [16];
    md5_words_t      work;
    md5_round_ctrl_t rctrl;
    logic            s_acc;
    logic            m_acc;
    logic [5:0]      pos;
    logic [63:0]     bit_len;

    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = m_tvalid && m_tready;
    assign pos     = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};

    md5_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rctrl),
        .cv_in    (cv_reg),
        .msg_word (buf_reg[md5_msg_index(round_reg)]),
        .work_out (work)
    );

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        eom_next   = eom_reg;
        round_next = round_reg;
        oidx_next  = oidx_reg;
        count_next = count_reg;
        cv_next    = cv_reg;
        buf_next   = buf_reg;
        rctrl      = '{load: 1'b0, step: 1'b0, round: round_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        buf_next[pos[5:2]] = md5_put_byte(buf_reg[pos[5:2]], pos[1:0], s_tdata);
                        count_next = count_reg + 61'd1;
                    end
                    if (s_tuser && pos == 6'd63) begin
                        rctrl.load = 1'b1;
                        round_next = '0;
                        phase_next = PH_DATA;
                        eom_next   = s_tlast;
                        state_next = S_RUN;
                    end else if (s_tlast) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_RUN: begin
                rctrl.step = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    cv_next[i] = cv_reg[i] + work[i];
                end
                unique case (phase_reg)
                    PH_DATA:  state_next = eom_reg ? S_PAD : S_IDLE;
                    PH_EXTRA: state_next = S_EXTRA;
                    default:  state_next = S_OUT;
                endcase
                eom_next = 1'b0;
            end
            S_PAD: begin
                for (int k = 0; k < 16; k++) begin
                    if (4'(k) > pos[5:2]) begin
                        buf_next[k] = '0;
                    end
                end
                buf_next[pos[5:2]] = md5_put_byte(buf_reg[pos[5:2]], pos[1:0], MD5_PAD_BYTE);
                if (pos >= 6'd56) begin
                    phase_next = PH_EXTRA;
                end else begin
                    buf_next[14] = bit_len[31:0];
                    buf_next[15] = bit_len[63:32];
                    phase_next   = PH_FINAL;
                end
                rctrl.load = 1'b1;
                round_next = '0;
                state_next = S_RUN;
            end
            S_EXTRA: begin
                for (int k = 0; k < 14; k++) begin
                    buf_next[k] = '0;
                end
                buf_next[14] = bit_len[31:0];
                buf_next[15] = bit_len[63:32];
                phase_next   = PH_FINAL;
                rctrl.load   = 1'b1;
                round_next   = '0;
                state_next   = S_RUN;
            end
            S_OUT: begin
                if (m_acc) begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3) begin
                        for (int i = 0; i < 4; i++) begin
                            cv_next[i] = MD5_INIT[i];
                        end
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            eom_reg   <= 1'b0;
            round_reg <= '0;
            oidx_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                cv_reg[i] <= MD5_INIT[i];
            end
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            eom_reg   <= eom_next;
            round_reg <= round_next;
            oidx_reg  <= oidx_next;
            count_reg <= count_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = cv_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 2'd3);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("Input accepted while digest words are pending.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && round_reg == 6'd63) |=> (state_reg == S_ADD))
        else $error("Chaining add did not follow the last round.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser && pos == 6'd63) |=> (state_reg == S_RUN && round_reg == 6'd0))
        else $error("Full block did not start compression.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> (state_reg == S_IDLE && count_reg == '0))
        else $error("Engine did not return to idle after the last digest word.");

endmodule
